// ----- sv/srird_pkg.sv -----
// Shared types, constants and codes for the sparse-run image row decoder.
package srird_pkg;

    // Defaults for the top-level parameters.
    localparam int PALETTE_ENTRIES_DEF = 65536;
    localparam int COORD_BITS_DEF      = 12;

    // Depth of the command queue between the parser and the palette stage.
    localparam int QUEUE_DEPTH = 4;

    // Widths fixed by the request and result fields.
    localparam int INDEX_BITS = 16;
    localparam int COLOR_BITS = 32;
    localparam int FIELD_BITS = 12;

    // Configuration register map (register index taken from paddr[2]).
    localparam int            PADDR_BITS      = 3;
    localparam logic          REG_TOKEN_CHARS = 1'b0;
    localparam logic [1:0]    TOKEN_CHARS_RST = 2'd1;
    localparam logic [1:0]    TOKEN_CHARS_TWO = 2'd2;

    // Operation codes of an input request.
    localparam logic OP_PALETTE_WRITE = 1'b0;
    localparam logic OP_ROW_BYTE      = 1'b1;

    // Character codes the parser recognises.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_ROW    = 3'd1,
        PH_GAP    = 3'd2,
        PH_START  = 3'd3,
        PH_COUNT  = 3'd4,
        PH_TOKEN  = 3'd5,
        PH_DONE   = 3'd6,
        PH_TOKEN2 = 3'd7
    } phase_t;

    // One input request.
    typedef struct packed {
        logic                  operation;
        logic [7:0]            row_byte;
        logic                  last_byte;
        logic [INDEX_BITS-1:0] palette_index;
        logic [COLOR_BITS-1:0] palette_color;
    } item_t;

    // One result request.
    typedef struct packed {
        logic [FIELD_BITS-1:0] pixel_row;
        logic [FIELD_BITS-1:0] pixel_column;
        logic [COLOR_BITS-1:0] pixel_color;
    } pixel_t;

    // Command passed from the parser to the palette stage.
    typedef struct packed {
        logic                  is_write;
        logic [INDEX_BITS-1:0] index;
        logic [COLOR_BITS-1:0] color;
        logic [FIELD_BITS-1:0] row;
        logic [FIELD_BITS-1:0] column;
    } cmd_t;

endpackage

// ----- sv/srird_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srird_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/srird_front.sv -----
// Front end: accepts requests, parses row bytes and issues palette commands.
module srird_front
    import srird_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  item_t      item,
    input  logic [1:0] token_chars,
    output logic       push,
    output cmd_t       cmd
);

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    phase_t                phase_reg, phase_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] start_reg, start_next;
    logic [COORD_BITS-1:0] count_reg, count_next;
    logic [COORD_BITS-1:0] pos_reg, pos_next;
    logic [7:0]            first_reg, first_next;

    logic [7:0]            b;
    logic                  is_digit;
    logic                  is_end;
    logic                  do_gap;
    logic                  do_emit;
    logic [INDEX_BITS-1:0] code;
    logic [COORD_BITS:0]   col_sum;
    logic [COORD_BITS:0]   pos_inc;
    logic [COORD_BITS-1:0] col_sat;
    logic [COORD_BITS+FIELD_BITS-1:0] row_wide;
    logic [COORD_BITS+FIELD_BITS-1:0] col_wide;

    // Decimal accumulate with saturation at the largest coordinate.
    function automatic logic [COORD_BITS-1:0] acc_digit(
        input logic [COORD_BITS-1:0] v,
        input logic [7:0]            d
    );
        logic [COORD_BITS+3:0] w;
        logic [COORD_BITS+3:0] n;
        w = {4'b0, v};
        n = (w << 3) + (w << 1) + {{COORD_BITS{1'b0}}, d[3:0]};
        if (n > {4'b0, COORD_MAX})
        begin
            return COORD_MAX;
        end
        return n[COORD_BITS-1:0];
    endfunction

    // Byte classes.
    assign b        = item.row_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_end   = (b == CH_NUL) || (b == CH_CR) || (b == CH_LF);

    // Pixel coordinates for a token completed by this byte.
    assign col_sum  = {1'b0, start_reg} + {1'b0, pos_reg};
    assign pos_inc  = {1'b0, pos_reg} + {{COORD_BITS{1'b0}}, 1'b1};
    assign col_sat  = col_sum[COORD_BITS] ? COORD_MAX : col_sum[COORD_BITS-1:0];
    assign row_wide = {{FIELD_BITS{1'b0}}, row_reg};
    assign col_wide = {{FIELD_BITS{1'b0}}, col_sat};

    // Parser next state.
    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        start_next = start_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        first_next = first_reg;
        do_gap     = 1'b0;
        do_emit    = 1'b0;
        code       = {8'b0, b};

        if (item.operation == OP_ROW_BYTE)
        begin
            if (phase_reg == PH_SKIP)
            begin
                phase_next = PH_ROW;
            end
            else if (phase_reg == PH_DONE)
            begin
                phase_next = PH_DONE;
            end
            else if (is_end)
            begin
                phase_next = PH_DONE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_ROW:
                    begin
                        if (is_digit)
                        begin
                            row_next = acc_digit(row_reg, b);
                        end
                        else
                        begin
                            do_gap = 1'b1;
                        end
                    end
                    PH_GAP:
                    begin
                        do_gap = 1'b1;
                    end
                    PH_START:
                    begin
                        if (is_digit)
                        begin
                            start_next = acc_digit(start_reg, b);
                        end
                        else if (b == CH_COMMA)
                        begin
                            count_next = '0;
                            phase_next = PH_COUNT;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_COUNT:
                    begin
                        if (is_digit)
                        begin
                            count_next = acc_digit(count_reg, b);
                        end
                        else if (b == CH_SPACE)
                        begin
                            pos_next   = '0;
                            phase_next = (count_reg == '0) ? PH_GAP : PH_TOKEN;
                        end
                        else
                        begin
                            phase_next = PH_GAP;
                        end
                    end
                    PH_TOKEN:
                    begin
                        if (token_chars == TOKEN_CHARS_TWO)
                        begin
                            first_next = b;
                            phase_next = PH_TOKEN2;
                        end
                        else
                        begin
                            do_emit = 1'b1;
                        end
                    end
                    PH_TOKEN2:
                    begin
                        code    = {first_reg, b};
                        do_emit = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_DONE;
                    end
                endcase

                // A place where a run may begin.
                if (do_gap)
                begin
                    if ((b == CH_SPACE) || (b == CH_TAB))
                    begin
                        phase_next = PH_GAP;
                    end
                    else if (is_digit)
                    begin
                        start_next = {{(COORD_BITS-4){1'b0}}, b[3:0]};
                        phase_next = PH_START;
                    end
                    else if (b == CH_COMMA)
                    begin
                        start_next = '0;
                        count_next = '0;
                        phase_next = PH_COUNT;
                    end
                    else
                    begin
                        phase_next = PH_DONE;
                    end
                end

                // Token complete: advance within the run.
                if (do_emit)
                begin
                    pos_next   = pos_inc[COORD_BITS-1:0];
                    phase_next = (pos_inc >= {1'b0, count_reg}) ? PH_GAP : PH_TOKEN;
                end
            end

            // The marked final byte returns the parser to the start of a row.
            if (item.last_byte)
            begin
                phase_next = PH_SKIP;
                row_next   = '0;
                start_next = '0;
                count_next = '0;
                pos_next   = '0;
                first_next = '0;
            end
        end
    end

    // Command towards the palette stage.
    always_comb
    begin
        cmd.is_write = (item.operation == OP_PALETTE_WRITE);
        cmd.index    = cmd.is_write ? item.palette_index : code;
        cmd.color    = item.palette_color;
        cmd.row      = row_wide[FIELD_BITS-1:0];
        cmd.column   = col_wide[FIELD_BITS-1:0];
        push         = accept && (cmd.is_write || do_emit);
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            row_reg   <= '0;
            start_reg <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            first_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            start_reg <= start_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            first_reg <= first_next;
        end
    end

endmodule

// ----- sv/srird_queue.sv -----
// Short command queue between the parser and the palette stage.
module srird_queue
    import srird_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- sv/srird_back.sv -----
// Back end: palette memory and the pixel output register.
module srird_back
    import srird_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   head_valid,
    input  cmd_t   head_cmd,
    output logic   pop,
    output logic   pixel_valid,
    input  logic   pixel_stall,
    output pixel_t pixel
);

    localparam int ADDR_BITS = $clog2(PALETTE_ENTRIES);

    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] out_row_reg;
    logic [FIELD_BITS-1:0] out_col_reg;
    logic [COLOR_BITS-1:0] rd_color;
    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_BITS-1:0]  ram_addr;

    // Writes always drain; a read waits until the output register is free.
    assign pop      = head_valid && (head_cmd.is_write || !out_valid_reg || !pixel_stall);
    assign ram_we   = pop && head_cmd.is_write;
    assign ram_re   = pop && !head_cmd.is_write;
    assign ram_addr = head_cmd.index[ADDR_BITS-1:0];

    srird_ram #(
        .WIDTH (COLOR_BITS),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (head_cmd.color),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (rd_color)
    );

    // Output valid follows reads; it drops when the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ram_re)
        begin
            out_valid_next = 1'b1;
        end
        else if (!pixel_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Coordinates travel alongside the palette read.
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            out_row_reg <= head_cmd.row;
            out_col_reg <= head_cmd.column;
        end
    end

    assign pixel_valid        = out_valid_reg;
    assign pixel.pixel_row    = out_row_reg;
    assign pixel.pixel_column = out_col_reg;
    assign pixel.pixel_color  = rd_color;

endmodule

// ----- sv/sparse_run_image_row_decoder_unit.sv -----
// Top level of the sparse-run image row decoder.
// The block takes one request per clock, either a palette write or one byte of a text
// image row, and delivers at most one pixel write per clock; a parsed token is registered in the
// queue and then read from the palette RAM into the output once the output register is free. The
// parser issues commands into a four-entry queue that feeds a single-write, single-read palette
// RAM, so the input stalls only when that queue fills behind a stalled output. The palette
// RAM is not cleared after reset: entries must be written before a token uses them.
module sparse_run_image_row_decoder_unit
    import srird_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int COORD_BITS      = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output pixel_t                pixel,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [1:0] token_chars_reg;
    logic       accept;
    logic       push;
    cmd_t       push_cmd;
    logic       pop;
    logic       full;
    logic       head_valid;
    cmd_t       head_cmd;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOKEN_CHARS) ? {30'b0, token_chars_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_chars_reg <= TOKEN_CHARS_RST;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOKEN_CHARS))
        begin
            token_chars_reg <= pwdata[1:0];
        end
    end

    // Request handshake.
    assign item_stall = full;
    assign accept     = item_valid && !full;

    srird_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .token_chars (token_chars_reg),
        .push        (push),
        .cmd         (push_cmd)
    );

    srird_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    srird_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel)
    );

endmodule

// ----- sv/srird_checker.sv -----
// Port-level checks for the sparse-run image row decoder, bound to the top level.
module srird_checker
    import srird_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pixel_valid,
    input logic                  pixel_stall,
    input pixel_t                pixel,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic                  pready,
    input logic [PADDR_BITS-1:0] paddr,
    input logic [31:0]           pwdata,
    input logic [31:0]           prdata
);

    // No result is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !pixel_valid)
        else $error("pixel offered during reset");

    // A stalled result stays offered and unchanged.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
        else $error("stalled pixel changed or vanished");

    // The token width register reads back what was last written to it.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_TOKEN_CHARS)
        |=> (paddr[2] != REG_TOKEN_CHARS) || (prdata[1:0] == $past(pwdata[1:0])))
        else $error("token width register does not read back");

    // Only the two low bits of read data carry a value.
    a_cfg_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite |-> prdata[31:2] == 30'b0)
        else $error("unused read data bits set");

endmodule

bind sparse_run_image_row_decoder_unit srird_checker u_srird_checker (.*);

// ----- verif/tb.sv -----
// Self-checking testbench for the sparse-run image row decoder unit.
`timescale 1ns / 100ps

module tb
    import srird_pkg::*;
();

    localparam int          CLK_PERIOD       = 10;
    localparam int          RESET_CYCLES     = 12;
    localparam int          SETTLE_CYCLES    = 16;
    localparam int          HOLDOFF_CYCLES   = 300;
    localparam int          TIMEOUT_NS       = 5_000_000;
    localparam int unsigned COORD_MAX        = (1 << COORD_BITS_DEF) - 1;
    localparam logic        REG_SPARE        = 1'b1;
    localparam logic [1:0]  TOKEN_CHARS_ZERO = 2'd0;
    localparam logic [1:0]  TOKEN_CHARS_MAX  = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    item_t                 item;
    logic                  pixel_valid;
    logic                  pixel_stall;
    pixel_t                pixel;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Decoder state as the testbench expects it to be.
    phase_t      ph;
    int unsigned row_num;
    int unsigned run_start;
    int unsigned run_count;
    int unsigned run_pos;
    bit [7:0]    tok_hi;
    bit [1:0]    tok_chars;
    bit [31:0]   palette_mem [0:65535];
    bit          palette_set [0:65535];

    // Pixels predicted but not yet seen at the output, oldest first.
    pixel_t      pending_pixels [$];
    bit [7:0]    row_q [$];

    bit          tx_idling = 1'b1;
    bit          rx_idling = 1'b1;
    int unsigned holdoff_request = 0;
    bit          holding = 1'b0;
    int unsigned longest_holdoff = 0;

    int unsigned mismatch_count = 0;
    int unsigned items_sent = 0;
    int unsigned rows_sent = 0;
    int unsigned palette_fills = 0;
    int unsigned pixels_checked = 0;
    int unsigned input_stall_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sparse_run_image_row_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic bit is_digit(input bit [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit is_end(input bit [7:0] b);
        return b == CH_NUL || b == CH_CR || b == CH_LF;
    endfunction

    // Decimal accumulation with saturation at the coordinate maximum.
    function automatic int unsigned acc_digit(input int unsigned v, input bit [7:0] b);
        int unsigned n;
        n = v * 10 + 32'(b - CH_ZERO);
        return (n > COORD_MAX) ? COORD_MAX : n;
    endfunction

    function automatic void restart_row();
        ph        = PH_SKIP;
        row_num   = 0;
        run_start = 0;
        run_count = 0;
        run_pos   = 0;
        tok_hi    = '0;
    endfunction

    // A byte where a run may begin: blanks, start column digits or a comma.
    function automatic void run_begin(input bit [7:0] b);
        if (b == CH_SPACE || b == CH_TAB)
        begin
            ph = PH_GAP;
        end
        else if (is_digit(b))
        begin
            run_start = 32'(b - CH_ZERO);
            ph = PH_START;
        end
        else if (b == CH_COMMA)
        begin
            run_start = 0;
            run_count = 0;
            ph = PH_COUNT;
        end
        else
        begin
            ph = PH_DONE;
        end
    endfunction

    // Tells whether this byte would look up the palette, and which entry.
    function automatic bit token_read(input bit [7:0] b, output bit [15:0] code);
        code = {8'h00, b};
        if (ph == PH_SKIP || ph == PH_DONE || is_end(b))
            return 1'b0;
        if (ph == PH_TOKEN && tok_chars != TOKEN_CHARS_TWO)
            return 1'b1;
        if (ph == PH_TOKEN2)
        begin
            code = {tok_hi, b};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void put_pixel(input bit [15:0] code);
        pixel_t      px;
        int unsigned col;
        col = run_start + run_pos;
        if (col > COORD_MAX)
            col = COORD_MAX;
        px.pixel_row    = FIELD_BITS'(row_num);
        px.pixel_column = FIELD_BITS'(col);
        px.pixel_color  = palette_mem[code];
        pending_pixels.push_back(px);
        run_pos++;
        ph = (run_pos >= run_count) ? PH_GAP : PH_TOKEN;
    endfunction

    // Advances the expected parser by one accepted row byte.
    function automatic void advance_row(input bit [7:0] b, input bit last);
        if (ph == PH_SKIP)
        begin
            ph = PH_ROW;
        end
        else if (ph != PH_DONE)
        begin
            if (is_end(b))
            begin
                ph = PH_DONE;
            end
            else
            begin
                case (ph)
                    PH_ROW:
                    begin
                        if (is_digit(b))
                            row_num = acc_digit(row_num, b);
                        else
                            run_begin(b);
                    end
                    PH_GAP: run_begin(b);
                    PH_START:
                    begin
                        if (is_digit(b))
                        begin
                            run_start = acc_digit(run_start, b);
                        end
                        else if (b == CH_COMMA)
                        begin
                            run_count = 0;
                            ph = PH_COUNT;
                        end
                        else
                        begin
                            ph = PH_DONE;
                        end
                    end
                    PH_COUNT:
                    begin
                        if (is_digit(b))
                        begin
                            run_count = acc_digit(run_count, b);
                        end
                        else if (b == CH_SPACE)
                        begin
                            run_pos = 0;
                            ph = (run_count == 0) ? PH_GAP : PH_TOKEN;
                        end
                        else
                        begin
                            ph = PH_GAP;
                        end
                    end
                    PH_TOKEN:
                    begin
                        if (tok_chars == TOKEN_CHARS_TWO)
                        begin
                            tok_hi = b;
                            ph = PH_TOKEN2;
                        end
                        else
                        begin
                            put_pixel({8'h00, b});
                        end
                    end
                    PH_TOKEN2: put_pixel({tok_hi, b});
                    default: ph = PH_DONE;
                endcase
            end
        end
        if (last)
            restart_row();
    endfunction

    // Output stall generator; a requested hold-off is counted out here.
    initial
    begin : output_stall_gen
        int unsigned n;
        pixel_stall <= 1'b0;
        forever
        begin
            if (holdoff_request != 0)
            begin
                n = holdoff_request;
                holdoff_request = 0;
                holding = 1'b1;
                pixel_stall <= 1'b1;
                repeat (n) @(posedge clk);
                holding = 1'b0;
                if (n > longest_holdoff)
                    longest_holdoff = n;
            end
            else if (rx_idling && $urandom_range(0, 3) == 0)
            begin
                pixel_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                pixel_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Compares every accepted pixel with the oldest prediction.
    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n)
        begin
            if (item_valid && item_stall)
                input_stall_cycles++;
            if (pixel_valid && !pixel_stall)
            begin
                if (pending_pixels.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected pixel row %0d col %0d colour %08h",
                                            pixel.pixel_row, pixel.pixel_column,
                                            pixel.pixel_color));
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (pixel.pixel_row !== want.pixel_row)
                        flag_mismatch($sformatf("pixel_row %0d, expected %0d",
                                                pixel.pixel_row, want.pixel_row));
                    if (pixel.pixel_column !== want.pixel_column)
                        flag_mismatch($sformatf("pixel_column %0d, expected %0d",
                                                pixel.pixel_column, want.pixel_column));
                    if (pixel.pixel_color !== want.pixel_color)
                        flag_mismatch($sformatf("pixel_color %08h, expected %08h",
                                                pixel.pixel_color, want.pixel_color));
                end
            end
        end
    end

    function automatic item_t random_item();
        item_t it;
        it.operation     = OP_ROW_BYTE;
        it.row_byte      = 8'($urandom);
        it.last_byte     = 1'($urandom);
        it.palette_index = 16'($urandom);
        it.palette_color = $urandom;
        return it;
    endfunction

    // Offers one request and waits until it is taken; valid stays high afterwards.
    task automatic send_item(input item_t it);
        if (tx_idling && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        items_sent++;
        if (it.operation == OP_PALETTE_WRITE)
        begin
            palette_mem[it.palette_index] = it.palette_color;
            palette_set[it.palette_index] = 1'b1;
        end
        else
        begin
            advance_row(it.row_byte, it.last_byte);
        end
    endtask

    task automatic send_colour(input bit [15:0] index, input bit [31:0] colour);
        item_t it;
        it = random_item();
        it.operation     = OP_PALETTE_WRITE;
        it.palette_index = index;
        it.palette_color = colour;
        send_item(it);
    endtask

    // A token never reads an entry that was not written: it is loaded first.
    task automatic send_byte(input bit [7:0] b, input bit last);
        item_t    it;
        bit [15:0] code;
        if (token_read(b, code) && !palette_set[code])
        begin
            send_colour(code, $urandom);
            palette_fills++;
        end
        it = random_item();
        it.row_byte  = b;
        it.last_byte = last;
        send_item(it);
    endtask

    task automatic send_row();
        foreach (row_q[i])
            send_byte(row_q[i], i == row_q.size() - 1);
        rows_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            row_q.push_back(s[i]);
    endtask

    task automatic append_number(input int unsigned v);
        if ($urandom_range(0, 7) == 0)
            row_q.push_back(CH_ZERO);
        push_text($sformatf("%0d", v));
    endtask

    function automatic int unsigned rand_coord();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(4000, 99999);
        return $urandom_range(0, COORD_MAX);
    endfunction

    // Token bytes are mostly free of end bytes so that runs usually finish.
    function automatic bit [7:0] token_byte();
        bit [7:0] b;
        b = 8'($urandom);
        if (is_end(b) && $urandom_range(0, 7) != 0)
            b = 8'h41 + 8'($urandom_range(0, 25));
        return b;
    endfunction

    // Builds a well-formed row with random content into row_q.
    task automatic build_row();
        int unsigned runs;
        int unsigned count;
        int unsigned kind;
        row_q.delete();
        row_q.push_back(8'($urandom));
        if ($urandom_range(0, 9) != 0)
            append_number(rand_coord());
        runs = $urandom_range(0, 4);
        for (int r = 0; r < runs; r++)
        begin
            repeat ($urandom_range(1, 3))
                row_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            if ($urandom_range(0, 9) != 0)
                append_number(rand_coord());
            row_q.push_back(CH_COMMA);
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                count = 0;
            end
            else if (kind == 1)
            begin
                count = 0;
                push_text("0");
            end
            else if (kind == 2 && r == runs - 1)
            begin
                // Saturating count; the row ends part way through the run.
                append_number($urandom_range(4096, 99999));
                count = $urandom_range(1, 6);
            end
            else
            begin
                count = $urandom_range(1, 8);
                append_number(count);
            end
            row_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(33, 126))
                                                         : CH_SPACE);
            repeat (count * ((tok_chars == TOKEN_CHARS_TWO) ? 2 : 1))
                row_q.push_back(token_byte());
        end
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       row_q.push_back(CH_NUL);
                1:       row_q.push_back(CH_CR);
                default: row_q.push_back(CH_LF);
            endcase
            repeat ($urandom_range(0, 3))
                row_q.push_back(8'($urandom));
        end
    endtask

    // Waits until every predicted pixel is out and the block has settled.
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input bit [PADDR_BITS-1:0] addr,
                              input bit [31:0] data, output bit [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Sets the token width, pokes the spare address and reads the register back.
    task automatic set_token_chars(input bit [1:0] value);
        bit [31:0] rd;
        wait_idle();
        apb_access(1'b1, PADDR_BITS'({REG_TOKEN_CHARS, 2'b00}), 32'(value), rd);
        tok_chars = value;
        apb_access(1'b1, PADDR_BITS'({REG_SPARE, 2'b00}), $urandom, rd);
        apb_access(1'b0, PADDR_BITS'({REG_TOKEN_CHARS, 2'b00}), 32'd0, rd);
        if (rd[1:0] !== tok_chars)
            flag_mismatch($sformatf("token_chars reads %0d, expected %0d", rd[1:0], tok_chars));
    endtask

    // Saturating row, the last columns, a skipped NUL and the widest palette entries.
    task automatic test_directed_extremes();
        send_colour(16'hFFFF, 32'hFFFF_FFFF);
        send_colour(16'h0000, 32'h0000_0000);
        row_q.delete();
        row_q.push_back(CH_NUL);
        push_text("9999\t4094,2 A");
        row_q.push_back(8'hFF);
        send_row();
    endtask

    // Missing numbers, a zero count, a dropped byte after the count, an end byte
    // inside a run with ignored bytes after it, and a syntax break.
    task automatic test_directed_special();
        row_q.delete();
        push_text("r ,0 7,1x3,2 Q");
        row_q.push_back(CH_LF);
        push_text("Z");
        send_row();
        row_q.delete();
        push_text("a1 5!Z");
        send_row();
    endtask

    // Two-byte tokens: the top palette entry, then a row ended between token bytes.
    task automatic test_two_char_tokens();
        row_q.delete();
        push_text("x1 0,2 ");
        row_q.push_back(8'hFF);
        row_q.push_back(8'hFF);
        push_text("A");
        row_q.push_back(CH_CR);
        send_row();
    endtask

    task automatic test_random_rows(input int unsigned n);
        int unsigned target;
        int unsigned pick;
        string       syntax;
        syntax = "0123456789, \t\r";
        target = items_sent + n;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                send_colour(16'($urandom), $urandom);
            end
            else
            begin
                build_row();
                if (pick == 1)
                begin
                    // Noise: short rows of syntax characters and random bytes.
                    row_q.delete();
                    repeat ($urandom_range(1, 16))
                        row_q.push_back($urandom_range(0, 1)
                                        ? 8'(syntax[$urandom_range(0, syntax.len() - 1)])
                                        : 8'($urandom));
                end
                else if (pick <= 3 && row_q.size() > 1)
                begin
                    row_q[$urandom_range(1, row_q.size() - 1)] = 8'($urandom);
                end
                send_row();
            end
        end
    endtask

    // The output holds off long enough for the block to fill and stall its input;
    // afterwards the sender pauses until every pixel has come back.
    task automatic test_output_holdoff();
        bit saved;
        wait_idle();
        saved = tx_idling;
        tx_idling = 1'b0;
        holdoff_request = HOLDOFF_CYCLES;
        while (!holding) @(posedge clk);
        row_q.delete();
        push_text("p5 10,40 ");
        repeat (40 * ((tok_chars == TOKEN_CHARS_TWO) ? 2 : 1))
            row_q.push_back(token_byte());
        send_row();
        tx_idling = saved;
        wait_idle();
    endtask

    initial
    begin : main_sequence
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        restart_row();
        tok_chars = TOKEN_CHARS_RST;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_directed_special();
        set_token_chars(TOKEN_CHARS_TWO);
        test_two_char_tokens();
        test_random_rows(400);
        set_token_chars(TOKEN_CHARS_ZERO);
        test_random_rows(300);
        set_token_chars(TOKEN_CHARS_MAX);
        test_random_rows(300);
        set_token_chars(TOKEN_CHARS_TWO);
        test_output_holdoff();
        test_random_rows(250);
        set_token_chars(TOKEN_CHARS_RST);
        // Closing stretch at full rate on both sides.
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        test_random_rows(200);
        wait_idle();

        $display("Covered %0d requests in %0d rows, %0d palette loads for tokens.",
                 items_sent, rows_sent, palette_fills);
        $display("%0d pixels checked; %0d-cycle output hold-off; input held for %0d cycles.",
                 pixels_checked, longest_holdoff, input_stall_cycles);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : run_limit
        #(TIMEOUT_NS);
        $display("Timed out with %0d pixels still expected.", pending_pixels.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
